@@ design/srmap_pkg.sv @@
// ----------------------------------------------------------------------------
// srmap_pkg
// Shared constants, codes and types of the source range map.
// ----------------------------------------------------------------------------
package srmap_pkg;

   localparam int MAX_RANGES   = 64;
   localparam int RESULT_LIMIT = 64;
   localparam int IDX_W        = $clog2(MAX_RANGES);
   localparam int CNT_W        = $clog2(MAX_RANGES + 1);
   localparam int NUM_W        = $clog2(RESULT_LIMIT);
   localparam int CUR_W        = 32 + IDX_W;
   localparam int ENTRY_W      = 64;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_LOCATE = 2'd1,
      CMD_SUBMAP = 2'd2,
      CMD_TAIL   = 2'd3
   } srmap_cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2,
      ST_ZERO = 2'd3
   } srmap_status_type;

   typedef struct packed {
      srmap_cmd_type cmd;
      logic [31:0]   position;
      logic [31:0]   offset;
      logic [31:0]   length;
      logic          zero_len;
   } srmap_item_type;

endpackage

@@ design/srmap_ram.sv @@
// ----------------------------------------------------------------------------
// srmap_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module srmap_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/srmap_front.sv @@
// ----------------------------------------------------------------------------
// srmap_front
// Input stage: accepts request items, decodes the command and flags
// zero lengths, and holds one item for the command queue.
// ----------------------------------------------------------------------------
module srmap_front
   import srmap_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [95:0]    req_tdata,
   input  logic [1:0]     req_tuser,
   output srmap_item_type item,
   output logic           item_valid,
   input  logic           item_ready
);

   logic           valid_ff;
   logic           valid_in;
   srmap_item_type item_ff;
   srmap_item_type item_in;

   assign req_tready = !valid_ff || item_ready;

   always_comb begin
      item_in.cmd      = srmap_cmd_type'(req_tuser);
      item_in.position = req_tdata[31:0];
      item_in.offset   = req_tdata[63:32];
      item_in.length   = req_tdata[95:64];
      item_in.zero_len = (req_tdata[95:64] == 32'd0);
      valid_in         = req_tready ? req_tvalid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

@@ design/srmap_queue.sv @@
// ----------------------------------------------------------------------------
// srmap_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module srmap_queue
   import srmap_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  srmap_item_type in_item,
   input  logic           in_valid,
   output logic           in_ready,
   output srmap_item_type out_item,
   output logic           out_valid,
   input  logic           out_ready
);

   srmap_item_type   slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              push;
   logic              pop;

   assign in_ready  = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (fill_ff != QCNT_W'(0));
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

@@ design/srmap_back.sv @@
// ----------------------------------------------------------------------------
// srmap_back
// Command engine: updates the range table on append and, while the result register
// is free, walks it one entry a cycle for locate, submap and tail, driving the register.
// ----------------------------------------------------------------------------
module srmap_back
   import srmap_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  srmap_item_type item,
   input  logic           item_valid,
   output logic           item_ready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [63:0]    rsp_tdata,   // out_start, out_length
   output logic [1:0]     rsp_tuser,   // status
   output logic           rsp_tlast
);

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   srmap_cmd_type    cmd_ff, cmd_in;
   logic [31:0]      pos_ff, pos_in;
   logic [31:0]      off_ff, off_in;
   logic [31:0]      remain_ff, remain_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CUR_W-1:0] cur_ff, cur_in;
   logic             found_ff, found_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [31:0]      last_s_ff, last_s_in;
   logic [31:0]      last_l_ff, last_l_in;

   logic [31:0]      out_start_ff, out_start_in;
   logic [31:0]      out_len_ff, out_len_in;
   srmap_status_type out_status_ff, out_status_in;
   logic             out_last_ff, out_last_in;

   logic                out_free;
   logic                out_load;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [ENTRY_W-1:0]  rd_data;

   logic [31:0]      rd_start;
   logic [31:0]      rd_len;
   logic             last_entry;
   logic [CUR_W-1:0] cur_end;
   logic             off_hit;
   logic             pos_hit;
   logic             hit;
   logic [31:0]      off_inner;
   logic [31:0]      skip;
   logic [31:0]      trim;
   logic [31:0]      em_start;
   logic [31:0]      em_len_raw;
   logic [31:0]      em_len;
   logic             em_final;

   logic [32:0]      ap_end_last;
   logic [32:0]      ap_new_end;
   logic [32:0]      ap_diff;
   logic             ap_merge;
   logic [31:0]      ap_len;

   srmap_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_RANGES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   // walk datapath; rd_data holds entry idx_ff
   always_comb begin
      rd_start   = rd_data[63:32];
      rd_len     = rd_data[31:0];
      last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      cur_end    = cur_ff + CUR_W'(rd_len);
      off_hit    = (CUR_W'(off_ff) < cur_end);
      pos_hit    = (pos_ff >= rd_start) &&
                   ({1'b0, pos_ff} < ({1'b0, rd_start} + {1'b0, rd_len}));
      hit        = (cmd_ff == CMD_SUBMAP) ? pos_hit : off_hit;
      off_inner  = off_ff - cur_ff[31:0];
      skip       = (cmd_ff == CMD_SUBMAP) ? (pos_ff - rd_start) : off_inner;
      trim       = found_ff ? 32'd0 : skip;
      em_start   = rd_start + trim;
      em_len_raw = rd_len - trim;
      em_len     = (em_len_raw > remain_ff) ? remain_ff : em_len_raw;
      em_final   = (em_len == remain_ff) || last_entry ||
                   (num_ff == NUM_W'(RESULT_LIMIT - 1));
   end

   // append datapath
   always_comb begin
      ap_end_last = {1'b0, last_s_ff} + {1'b0, last_l_ff};
      ap_merge    = (count_ff != CNT_W'(0)) && ({1'b0, item.position} <= ap_end_last);
      ap_new_end  = {1'b0, item.position} + {1'b0, item.length};
      ap_diff     = ap_new_end - {1'b0, last_s_ff};
      if (ap_new_end <= {1'b0, last_s_ff}) begin
         ap_len = 32'd0;
      end else if (ap_diff[32]) begin
         ap_len = 32'hFFFF_FFFF;
      end else begin
         ap_len = ap_diff[31:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      off_in        = off_ff;
      remain_in     = remain_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      found_in      = found_ff;
      num_in        = num_ff;
      last_s_in     = last_s_ff;
      last_l_in     = last_l_ff;
      out_start_in  = out_start_ff;
      out_len_in    = out_len_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      out_load      = 1'b0;
      item_ready    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = {item.position, item.length};

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid && out_free) begin
               item_ready    = 1'b1;
               out_load      = 1'b1;
               out_start_in  = 32'd0;
               out_len_in    = 32'd0;
               out_status_in = ST_OK;
               out_last_in   = 1'b1;
               cmd_in        = item.cmd;
               pos_in        = item.position;
               off_in        = item.offset;
               remain_in     = item.length;
               idx_in        = '0;
               cur_in        = '0;
               found_in      = 1'b0;
               num_in        = '0;
               unique case (item.cmd)
                  CMD_APPEND: begin
                     if (item.zero_len) begin
                        out_status_in = ST_ZERO;
                     end else if (ap_merge) begin
                        wr_en     = 1'b1;
                        wr_addr   = IDX_W'(count_ff - CNT_W'(1));
                        wr_data   = {last_s_ff, ap_len};
                        last_l_in = ap_len;
                     end else if (count_ff == CNT_W'(MAX_RANGES)) begin
                        out_status_in = ST_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = IDX_W'(count_ff);
                        last_s_in = item.position;
                        last_l_in = item.length;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_LOCATE: begin
                     if (count_ff == CNT_W'(0)) begin
                        out_status_in = ST_MISS;
                     end else begin
                        out_load = 1'b0;
                        state_in = S_WALK;
                     end
                  end
                  CMD_SUBMAP, CMD_TAIL: begin
                     if (count_ff == CNT_W'(0) || item.zero_len) begin
                        out_status_in = ST_MISS;
                     end else begin
                        out_load = 1'b0;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     out_status_in = ST_MISS;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (out_free) begin
               if (cmd_ff == CMD_LOCATE) begin
                  if (off_hit) begin
                     out_load      = 1'b1;
                     out_start_in  = rd_start + off_inner;
                     out_len_in    = 32'd0;
                     out_status_in = ST_OK;
                     out_last_in   = 1'b1;
                     state_in      = S_IDLE;
                  end else if (last_entry) begin
                     out_load      = 1'b1;
                     out_start_in  = 32'd0;
                     out_len_in    = 32'd0;
                     out_status_in = ST_MISS;
                     out_last_in   = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                     cur_in = cur_end;
                  end
               end else if (found_ff || hit) begin
                  out_load      = 1'b1;
                  out_start_in  = em_start;
                  out_len_in    = em_len;
                  out_status_in = ST_OK;
                  out_last_in   = em_final;
                  found_in      = 1'b1;
                  remain_in     = remain_ff - em_len;
                  num_in        = num_ff + NUM_W'(1);
                  idx_in        = idx_ff + IDX_W'(1);
                  if (em_final) begin
                     state_in = S_IDLE;
                  end
               end else if (last_entry) begin
                  out_load      = 1'b1;
                  out_start_in  = 32'd0;
                  out_len_in    = 32'd0;
                  out_status_in = ST_MISS;
                  out_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
                  cur_in = cur_end;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      off_ff        <= off_in;
      remain_ff     <= remain_in;
      cur_ff        <= cur_in;
      found_ff      <= found_in;
      num_ff        <= num_in;
      last_s_ff     <= last_s_in;
      last_l_ff     <= last_l_in;
      out_start_ff  <= out_start_in;
      out_len_ff    <= out_len_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_len_ff, out_start_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RANGES))
      else $error("range count above table size");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_ready |-> (state_ff == S_IDLE && out_free))
      else $error("queue popped while busy");

   a_walk_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("walk index past table end");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_status_in == ST_FULL) |-> (count_ff == CNT_W'(MAX_RANGES)))
      else $error("full status with room in table");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !out_load)
      else $error("result register overwritten while held");

endmodule

@@ design/source_range_map_core.sv @@
// ----------------------------------------------------------------------------
// source_range_map_core
// Ordered table of source ranges serving append, locate, submap and tail.
// ----------------------------------------------------------------------------
// Items enter through a one-item input stage and a two-item command queue,
// and reach the engine from the input register by way of a queue slot; the
// engine runs one command at a time. Append is done in the start step. Locate
// takes a start step, then scans table entries in order, up to the entry
// count. Submap and tail take a start step, then scan entries up to the
// first covering entry, then emit one result per entry, up to 64 results.
// The entry memory has a single read port, which delivers one entry a cycle
// to the scan while the result register is free; the scan stalls while a
// result is held waiting on rsp_tready.
// The table needs no clearing after reset; reads never reach an entry that
// was not written.
// ----------------------------------------------------------------------------
module source_range_map_core
   import srmap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // position, offset, length
   input  logic [1:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_start, out_length
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast
);

   srmap_item_type front_item;
   logic           front_valid;
   logic           front_ready;
   srmap_item_type queue_item;
   logic           queue_valid;
   logic           queue_ready;

   srmap_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item       (front_item),
      .item_valid (front_valid),
      .item_ready (front_ready)
   );

   srmap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (front_item),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_item  (queue_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready)
   );

   srmap_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (queue_item),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ sim/source_range_map_core_tb.sv @@
// ----------------------------------------------------------------------------
// source_range_map_core_tb
// Self-checking bench for the source range map core.
// ----------------------------------------------------------------------------
// Items are queued by a generator, sent by a clocked driver with random gaps,
// and mirrored into a local copy of the range table when accepted. Each
// accepted item adds its expected result items to a queue, and the monitor
// compares every result item field by field with the oldest entry. The run
// opens with directed items on an empty and a small table, fills the table
// with random traffic, then hits the full table and 32-bit extremes.
// ----------------------------------------------------------------------------
module source_range_map_core_tb;
   import srmap_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 216;
   localparam int BATCH_SIZE   = 8;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      srmap_cmd_type cmd;
      logic [31:0]   position;
      logic [31:0]   offset;
      logic [31:0]   length;
   } map_request_type;

   typedef struct {
      logic [31:0]      start;
      logic [31:0]      length;
      srmap_status_type status;
      logic             last;
   } mapped_piece_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // position, offset, length
   logic [1:0]  req_tuser = '0;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // out_start, out_length
   logic [1:0]  rsp_tuser;        // status
   logic        rsp_tlast;

   map_request_type  pending_requests[$];
   map_request_type  held_request;
   mapped_piece_type expected_pieces[$];
   logic [31:0]      tbl_start[MAX_RANGES];
   logic [31:0]      tbl_len[MAX_RANGES];
   int               tbl_count = 0;
   int               fail_count = 0;
   int               cycle_count;
   bit               calm = 1'b0;

   source_range_map_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void push_single(logic [31:0] start, srmap_status_type status);
      expected_pieces.push_back('{start: start, length: 32'd0, status: status, last: 1'b1});
   endfunction

   function automatic bit find_logical(logic [63:0] off, output int idx,
                                       output logic [63:0] inner);
      logic [63:0] cur;
      cur = 0;
      idx = 0;
      inner = 0;
      for (int i = 0; i < tbl_count; i++) begin
         if (off < cur + tbl_len[i]) begin
            idx = i;
            inner = off - cur;
            return 1'b1;
         end
         cur += tbl_len[i];
      end
      return 1'b0;
   endfunction

   function automatic void emit_pieces(int from_idx, logic [63:0] skip,
                                       logic [63:0] remain);
      logic [63:0] s;
      logic [63:0] l;
      int          i;
      int          n;
      i = from_idx;
      n = 0;
      while (i < tbl_count && remain != 0 && n < RESULT_LIMIT) begin
         s = tbl_start[i];
         l = tbl_len[i];
         if (i == from_idx) begin
            s += skip;
            l -= skip;
         end
         if (l > remain) l = remain;
         expected_pieces.push_back('{start: s[31:0], length: l[31:0], status: ST_OK,
                                     last: 1'b0});
         n++;
         remain -= l;
         i++;
      end
      expected_pieces[expected_pieces.size() - 1].last = 1'b1;
   endfunction

   function automatic void predict_ranges(map_request_type rq);
      logic [63:0] pos;
      logic [63:0] off;
      logic [63:0] len;
      logic [63:0] s;
      logic [63:0] ne;
      logic [63:0] nl;
      logic [63:0] inner;
      int          idx;
      bit          hit;
      pos = rq.position;
      off = rq.offset;
      len = rq.length;
      case (rq.cmd)
         CMD_APPEND: begin
            s = (tbl_count > 0) ? 64'(tbl_start[tbl_count - 1]) : 64'd0;
            if (len == 0) begin
               push_single(32'd0, ST_ZERO);
            end else if (tbl_count > 0 && pos <= s + tbl_len[tbl_count - 1]) begin
               ne = pos + len;
               nl = (ne > s) ? ne - s : 64'd0;
               if (nl > 64'hFFFF_FFFF) nl = 64'hFFFF_FFFF;
               tbl_len[tbl_count - 1] = nl[31:0];
               push_single(32'd0, ST_OK);
            end else if (tbl_count >= MAX_RANGES) begin
               push_single(32'd0, ST_FULL);
            end else begin
               tbl_start[tbl_count] = rq.position;
               tbl_len[tbl_count] = rq.length;
               tbl_count++;
               push_single(32'd0, ST_OK);
            end
         end
         CMD_LOCATE: begin
            if (find_logical(off, idx, inner)) begin
               s = tbl_start[idx] + inner;
               push_single(s[31:0], ST_OK);
            end else begin
               push_single(32'd0, ST_MISS);
            end
         end
         CMD_SUBMAP: begin
            hit = 1'b0;
            if (len != 0) begin
               for (int i = 0; i < tbl_count && !hit; i++) begin
                  s = tbl_start[i];
                  if (pos >= s && pos < s + tbl_len[i]) begin
                     hit = 1'b1;
                     emit_pieces(i, pos - s, len);
                  end
               end
            end
            if (!hit) push_single(32'd0, ST_MISS);
         end
         default: begin
            if (len != 0 && find_logical(off, idx, inner)) emit_pieces(idx, inner, len);
            else push_single(32'd0, ST_MISS);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_ranges(held_request);
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
               held_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {held_request.length, held_request.offset,
                              held_request.position};
               req_tuser  <= held_request.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      mapped_piece_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pieces.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual %h/%h/%b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_pieces.pop_front();
               check_field("start", want.start, rsp_tdata[31:0]);
               check_field("length", want.length, rsp_tdata[63:32]);
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 32);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic void queue_item(srmap_cmd_type cmd, logic [31:0] position,
                                      logic [31:0] offset, logic [31:0] length);
      pending_requests.push_back('{cmd: cmd, position: position, offset: offset,
                                   length: length});
   endfunction

   function automatic logic [63:0] mapped_total();
      logic [63:0] sum;
      sum = 0;
      for (int i = 0; i < tbl_count; i++) sum += tbl_len[i];
      return sum;
   endfunction

   function automatic logic [31:0] random_span();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return $urandom_range(600, 1);
      if (pick < 80) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_tvalid || expected_pieces.size() != 0)
         @(negedge clock);
   endtask

   // Appends march a cursor upward so the table fills; merges land within or at
   // the end of the last entry. Queries aim at live entries and offsets.
   task automatic queue_random_item(inout logic [63:0] cursor, inout int counted);
      map_request_type rq;
      int              pick;
      int              i;
      logic [63:0]     total;
      rq.cmd      = CMD_LOCATE;
      rq.position = $urandom;
      rq.offset   = $urandom;
      rq.length   = $urandom;
      total = mapped_total();
      pick = $urandom_range(99);
      if (pick < ((tbl_count < MAX_RANGES) ? 55 : 20)) begin
         rq.cmd = CMD_APPEND;
         pick = $urandom_range(99);
         if (pick < 8) begin
            rq.length = 0;
         end else begin
            rq.length = $urandom_range(200, 1);
            if (pick < 30 && tbl_count > 0) begin
               i = tbl_count - 1;
               rq.position = tbl_start[i] + $urandom_range(tbl_len[i]);
            end else begin
               rq.position = 32'(cursor + 64'($urandom_range(64, 1)));
            end
            if (rq.position + 64'(rq.length) > cursor) cursor = rq.position + 64'(rq.length);
         end
      end else if (pick < 70) begin
         rq.cmd = CMD_LOCATE;
         if ($urandom_range(9) != 0) rq.offset = $urandom_range(32'(total) + 4);
      end else if (pick < 85) begin
         rq.cmd = CMD_SUBMAP;
         if (tbl_count > 0 && $urandom_range(9) != 0) begin
            i = $urandom_range(tbl_count - 1);
            rq.position = tbl_start[i] + $urandom_range(tbl_len[i]);
            rq.length = random_span();
         end
      end else if (pick < 95) begin
         rq.cmd = CMD_TAIL;
         if ($urandom_range(9) != 0) begin
            rq.offset = $urandom_range(32'(total));
            rq.length = random_span();
         end
      end else begin
         rq.cmd = srmap_cmd_type'(2'($urandom_range(3, 1)));
      end
      if (rq.cmd != CMD_APPEND || rq.length != 0) counted++;
      pending_requests.push_back(rq);
   endtask

   initial begin
      logic [63:0] cursor;
      logic [31:0] tail_end;
      int          counted;
      int          batch;
      int          li;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table
      queue_item(CMD_LOCATE, $urandom, 32'd0, $urandom);
      queue_item(CMD_SUBMAP, 32'd0, $urandom, 32'd10);
      queue_item(CMD_TAIL, $urandom, 32'd0, 32'd10);
      queue_item(CMD_APPEND, 32'd100, $urandom, 32'd0);
      // merges: shrink, touch the end, collapse to zero, regrow
      queue_item(CMD_APPEND, 32'd100, $urandom, 32'd50);
      queue_item(CMD_APPEND, 32'd120, $urandom, 32'd10);
      queue_item(CMD_APPEND, 32'd130, $urandom, 32'd20);
      queue_item(CMD_APPEND, 32'd50, $urandom, 32'd10);
      queue_item(CMD_LOCATE, $urandom, 32'd0, $urandom);
      queue_item(CMD_APPEND, 32'd100, $urandom, 32'd40);
      queue_item(CMD_APPEND, 32'd300, $urandom, 32'd25);
      queue_item(CMD_APPEND, 32'd326, $urandom, 32'd30);
      queue_item(CMD_LOCATE, $urandom, 32'd0, $urandom);
      queue_item(CMD_LOCATE, $urandom, 32'd39, $urandom);
      queue_item(CMD_LOCATE, $urandom, 32'd40, $urandom);
      queue_item(CMD_LOCATE, $urandom, 32'd95, $urandom);
      queue_item(CMD_SUBMAP, 32'd110, $urandom, 32'd1000);
      queue_item(CMD_SUBMAP, 32'd310, $urandom, 32'd20);
      queue_item(CMD_SUBMAP, 32'd140, $urandom, 32'd5);
      queue_item(CMD_SUBMAP, 32'd100, $urandom, 32'd0);
      queue_item(CMD_TAIL, $urandom, 32'd50, 32'd0);
      queue_item(CMD_TAIL, $urandom, 32'd50, 32'd30);
      queue_item(CMD_TAIL, $urandom, 32'hFFFF_FFFF, 32'd1);
      wait_idle();

      cursor = 1000;
      counted = 0;
      batch = 0;
      while (counted < RANDOM_ITEMS) begin
         while (pending_requests.size() != 0) @(negedge clock);
         calm = (counted >= 100 && counted < 140);
         for (int k = 0; k < BATCH_SIZE; k++) queue_random_item(cursor, counted);
         batch++;
         if (batch % 8 == 0) wait_idle();
      end
      wait_idle();
      calm = 1'b0;

      // full table and 32-bit extremes
      li = tbl_count - 1;
      tail_end = tbl_start[li] + tbl_len[li];
      queue_item(CMD_APPEND, tail_end + 32'd1, $urandom, 32'd5);
      queue_item(CMD_TAIL, $urandom, 32'd0, 32'hFFFF_FFFF);
      queue_item(CMD_SUBMAP, tbl_start[0], $urandom, 32'hFFFF_FFFF);
      queue_item(CMD_APPEND, tail_end, $urandom, 32'hFFFF_FFFF);
      queue_item(CMD_APPEND, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF);
      queue_item(CMD_LOCATE, $urandom, 32'hFFFF_FFFF, $urandom);
      queue_item(CMD_TAIL, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_item(CMD_SUBMAP, 32'hFFFF_FFFE, $urandom, 32'hFFFF_FFFF);
      queue_item(CMD_LOCATE, $urandom, 32'd0, $urandom);
      wait_idle();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
